### hdl/integer_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: assertion macros
// Clocked on clk, disabled while rst is high; the using scope provides both.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define I2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/int2dec_pkg.sv
// ----------------------------------------------------------------------------
// int2dec_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package int2dec_pkg;

  localparam int VALUE_W    = 32;
  localparam int CMD_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int SEL_W      = 4;   // indexes NUM_DIGITS digits
  localparam int CNT_W      = 6;   // holds VALUE_W

  // Kind codes on cmd
  localparam logic [CMD_W-1:0] KIND_U8  = 3'd0;
  localparam logic [CMD_W-1:0] KIND_U16 = 3'd1;
  localparam logic [CMD_W-1:0] KIND_U32 = 3'd2;
  localparam logic [CMD_W-1:0] KIND_S8  = 3'd3;
  localparam logic [CMD_W-1:0] KIND_S16 = 3'd4;
  localparam logic [CMD_W-1:0] KIND_S32 = 3'd5;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Sequencer to BCD unit
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [SEL_W-1:0] sel;
  } ctrl_t;

endpackage

### hdl/int2dec_bcd_unit.sv
// ----------------------------------------------------------------------------
// int2dec_bcd_unit
// Shift-and-add-3 binary to BCD converter, one bit per shift, with a digit
// read port for the character sequencer.
// ----------------------------------------------------------------------------
module int2dec_bcd_unit (
  input  logic                                  clk,
  input  int2dec_pkg::ctrl_t                    ctrl,
  input  logic [int2dec_pkg::VALUE_W-1:0]       mag,
  output logic [int2dec_pkg::DIGIT_W-1:0]       digit
);

  logic [int2dec_pkg::VALUE_W-1:0] bin;
  logic [int2dec_pkg::NUM_DIGITS-1:0][int2dec_pkg::DIGIT_W-1:0] bcd;
  logic [int2dec_pkg::NUM_DIGITS-1:0][int2dec_pkg::DIGIT_W-1:0] corr;

  // add 3 to any digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int2dec_pkg::NUM_DIGITS; i++) begin
      corr[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= mag;
      bcd <= '0;
    end else if (ctrl.shift) begin
      // top bit of the top digit falls off; it is always zero
      bcd <= {corr[int2dec_pkg::NUM_DIGITS-1][int2dec_pkg::DIGIT_W-2:0],
              corr[int2dec_pkg::NUM_DIGITS-2:0],
              bin[int2dec_pkg::VALUE_W-1]};
      bin <= {bin[int2dec_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  assign digit = (ctrl.sel < int2dec_pkg::SEL_W'(int2dec_pkg::NUM_DIGITS))
                 ? bcd[ctrl.sel] : '0;

endmodule

### hdl/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts one integer of a given kind to its decimal text, one ASCII
// character per output word.
// ----------------------------------------------------------------------------
// One input word (cmd, value) becomes a run of ASCII characters, most
// significant first, with last set on the final one. Kinds u8/u16/u32 print
// zero-padded to 3/5/10 digits; s8/s16/s32 print '-' when negative and then
// the magnitude with no leading zeros (the most negative value prints
// exactly, zero prints as "0"). cmd codes 6 and 7 are taken and give no
// characters. Value bits above the kind's width are ignored. The input word is
// taken, then a shared shift-and-add-3 BCD unit runs one bit per cycle over the
// kind's width. Signed kinds then drop leading zeros one at a time (up to 9)
// and emit a minus sign first when negative. Characters leave at one per cycle
// while the output is not stalled. item_stall is high from the accept until
// the last character has been loaded into the output register; the next word
// is taken while that last character still waits downstream.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [int2dec_pkg::CMD_W-1:0]       cmd,
  input  logic [int2dec_pkg::VALUE_W-1:0]     value,
  // output channel
  output logic                                char_valid,
  input  logic                                char_stall,
  output logic [int2dec_pkg::CHAR_W-1:0]      char_code,
  output logic                                last
);

  // sequencer state
  int2dec_pkg::state_t                 state, state_next;
  logic [int2dec_pkg::CNT_W-1:0]       cnt, cnt_next;     // bits left to shift
  logic [int2dec_pkg::SEL_W-1:0]       ndig, ndig_next;   // digits left to send
  logic                                neg, neg_next;
  logic                                sgn, sgn_next;

  // kind decode
  logic                                kind_ok;
  logic                                kind_sgn;
  logic [int2dec_pkg::CNT_W-1:0]       kind_width;
  logic [int2dec_pkg::SEL_W-1:0]       kind_pad;
  logic [int2dec_pkg::VALUE_W-1:0]     kind_mask;
  logic [1:0]                          kind_align;        // 0: none, 1: <<16, 2: <<24
  logic [int2dec_pkg::VALUE_W-1:0]     raw;
  logic                                raw_neg;
  logic [int2dec_pkg::VALUE_W-1:0]     mag;
  logic [int2dec_pkg::VALUE_W-1:0]     mag_aligned;

  // BCD unit
  int2dec_pkg::ctrl_t                  ctrl;
  logic [int2dec_pkg::DIGIT_W-1:0]     digit;

  // output register load
  logic                                out_free;
  logic                                out_load;
  logic [int2dec_pkg::CHAR_W-1:0]      out_char;
  logic                                out_last;

  always_comb begin
    kind_ok    = 1'b1;
    kind_sgn   = 1'b0;
    kind_width = 6'd32;
    kind_pad   = 4'd10;
    kind_mask  = 32'hFFFF_FFFF;
    kind_align = 2'd0;
    raw_neg    = 1'b0;
    unique case (cmd)
      int2dec_pkg::KIND_U8: begin
        kind_width = 6'd8;  kind_pad = 4'd3;  kind_mask = 32'h0000_00FF; kind_align = 2'd2;
      end
      int2dec_pkg::KIND_U16: begin
        kind_width = 6'd16; kind_pad = 4'd5;  kind_mask = 32'h0000_FFFF; kind_align = 2'd1;
      end
      int2dec_pkg::KIND_U32: begin
        kind_width = 6'd32; kind_pad = 4'd10;
      end
      int2dec_pkg::KIND_S8: begin
        kind_sgn   = 1'b1;  kind_width = 6'd8;  kind_mask = 32'h0000_00FF;
        kind_align = 2'd2;  raw_neg = value[7];
      end
      int2dec_pkg::KIND_S16: begin
        kind_sgn   = 1'b1;  kind_width = 6'd16; kind_mask = 32'h0000_FFFF;
        kind_align = 2'd1;  raw_neg = value[15];
      end
      int2dec_pkg::KIND_S32: begin
        kind_sgn   = 1'b1;  raw_neg = value[31];
      end
      default: kind_ok = 1'b0;
    endcase

    raw = value & kind_mask;
    // two's complement magnitude; the most negative value stays 2^(w-1)
    mag = raw_neg ? ((~raw + 32'd1) & kind_mask) : raw;
    // left-align so the top bit of the kind shifts out first
    case (kind_align)
      2'd1:    mag_aligned = {mag[15:0], 16'd0};
      2'd2:    mag_aligned = {mag[7:0], 24'd0};
      default: mag_aligned = mag;
    endcase
  end

  assign out_free = !char_valid || !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= int2dec_pkg::ST_IDLE;
      cnt   <= '0;
      ndig  <= '0;
      neg   <= 1'b0;
      sgn   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ndig  <= ndig_next;
      neg   <= neg_next;
      sgn   <= sgn_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ndig_next  = ndig;
    neg_next   = neg;
    sgn_next   = sgn;
    item_stall = 1'b1;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.sel   = ndig - 4'd1;
    out_load   = 1'b0;
    out_char   = int2dec_pkg::ASCII_ZERO + {4'd0, digit};
    out_last   = (ndig == 4'd1);

    unique case (state)
      int2dec_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && kind_ok) begin
          ctrl.load  = 1'b1;
          cnt_next   = kind_width;
          // signed: start from the top digit and drop leading zeros
          ndig_next  = kind_sgn ? 4'(int2dec_pkg::NUM_DIGITS) : kind_pad;
          neg_next   = raw_neg;
          sgn_next   = kind_sgn;
          state_next = int2dec_pkg::ST_CONV;
        end
      end
      int2dec_pkg::ST_CONV: begin
        ctrl.shift = 1'b1;
        cnt_next   = cnt - 6'd1;
        if (cnt == 6'd1) begin
          state_next = sgn ? int2dec_pkg::ST_TRIM : int2dec_pkg::ST_EMIT;
        end
      end
      int2dec_pkg::ST_TRIM: begin
        if (ndig > 4'd1 && digit == 4'd0) begin
          ndig_next = ndig - 4'd1;
        end else begin
          state_next = neg ? int2dec_pkg::ST_SIGN : int2dec_pkg::ST_EMIT;
        end
      end
      int2dec_pkg::ST_SIGN: begin
        out_char = int2dec_pkg::ASCII_MINUS;
        out_last = 1'b0;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = int2dec_pkg::ST_EMIT;
        end
      end
      int2dec_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ndig_next = ndig - 4'd1;
          if (ndig == 4'd1) begin
            state_next = int2dec_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = int2dec_pkg::ST_IDLE;
    endcase
  end

  int2dec_bcd_unit u_bcd (
    .clk   (clk),
    .ctrl  (ctrl),
    .mag   (mag_aligned),
    .digit (digit)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_load) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_code <= out_char;
      last      <= out_last;
    end
  end

endmodule

### hdl/int2dec_checker.sv
// ----------------------------------------------------------------------------
// int2dec_checker
// Port-level checks for integer_to_decimal_ascii, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_decimal_ascii_macros.svh"

module int2dec_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_stall,
  input logic [int2dec_pkg::CMD_W-1:0]       cmd,
  input logic [int2dec_pkg::VALUE_W-1:0]     value,
  input logic                                char_valid,
  input logic                                char_stall,
  input logic [int2dec_pkg::CHAR_W-1:0]      char_code,
  input logic                                last
);

  logic known_take;
  logic out_held;
  logic char_ok;
  logic is_minus;

  assign known_take = item_valid && !item_stall && (cmd <= int2dec_pkg::KIND_S32);
  assign out_held   = char_valid && char_stall;
  assign is_minus   = (char_code == int2dec_pkg::ASCII_MINUS);
  assign char_ok    = (char_code >= int2dec_pkg::ASCII_ZERO &&
                       char_code <= int2dec_pkg::ASCII_NINE) || is_minus;

  // a known kind keeps the input busy while it is converted
  `I2D_ASSERT_NEXT(a_busy_after_take, known_take, item_stall, "input not busy after take")

  // a stalled output word holds
  `I2D_ASSERT_NEXT(a_out_hold, out_held, char_valid && $stable({char_code, last}), "word changed")

  // only digits or a minus sign leave the block
  `I2D_ASSERT_NOW(a_char_set, char_valid, char_ok, "character outside digits and minus")

  // a minus sign is always followed by digits
  `I2D_ASSERT_NOW(a_minus_not_last, char_valid && is_minus, !last, "minus sign flagged as last")

endmodule

bind integer_to_decimal_ascii int2dec_checker u_int2dec_checker (.*);
